[src/pidpi_pkg.sv]
// shared types and constants for the pid position/incremental unit
// no dependencies
package pidpi_pkg;

   localparam logic [1:0] CMD_POS     = 2'd0;
   localparam logic [1:0] CMD_INC     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_GAIN_P    = 3'd0;
   localparam logic [2:0] REG_GAIN_I    = 3'd1;
   localparam logic [2:0] REG_GAIN_D    = 3'd2;
   localparam logic [2:0] REG_OUT_LIM   = 3'd3;
   localparam logic [2:0] REG_INT_RANGE = 3'd4;
   localparam logic [2:0] REG_INT_LIM   = 3'd5;
   localparam logic [2:0] REG_ERR_TOL   = 3'd6;
   localparam logic [2:0] REG_RATE_TOL  = 3'd7;

   localparam int DIVIDEND_W = 47;
   localparam int GAIN_W     = 24;
   localparam int LIMIT_W    = 31;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] err;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] output_limit;
      logic [LIMIT_W-1:0] integral_range;
      logic [LIMIT_W-1:0] integral_limit;
      logic [LIMIT_W-1:0] error_tolerance;
      logic [LIMIT_W-1:0] rate_tolerance;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [GAIN_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_P, ST_D, ST_SUM, ST_DIV, ST_CLAMP, ST_ILO, ST_IHI,
      ST_IACC, ST_INC_I, ST_INC_Y, ST_Y
   } seq_state_type;

endpackage

[src/pidpi_front.sv]
// front end: accepts words, forms the saturated error, drops unused commands
// and holds a two-entry queue toward the back end; uses pidpi_pkg
module pidpi_front
   import pidpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         cmd,
   input  logic signed [31:0] setpoint,
   input  logic signed [31:0] measured,
   output logic               q_valid,
   output item_type           q_item,
   input  logic               q_pop
);

   item_type   entry_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       store;
   logic signed [32:0] diff;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];

   // saturate the difference to 32 bits
   always_comb begin
      diff = 33'(setpoint) - 33'(measured);
      entry_in.cmd = cmd;
      if (diff[32] != diff[31]) begin
         entry_in.err = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         entry_in.err = diff[31:0];
      end
      store = push && !full && (cmd != CMD_UNUSED);
   end

   always_ff @(posedge clock) begin
      if (store) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (store) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop && q_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(store) - 2'(q_pop && q_valid);
      end
   end

endmodule

[src/pidpi_div.sv]
// restoring divider, one quotient bit per cycle, for the integral bound
// uses pidpi_pkg
module pidpi_div
   import pidpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [GAIN_W-1:0]     rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [GAIN_W-1:0]     div_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;
   logic [GAIN_W:0]       trial;
   logic                  take;

   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign take     = (trial >= {1'b0, div_ff});
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? GAIN_W'(trial - {1'b0, div_ff}) : trial[GAIN_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

[src/pidpi_back.sv]
// back end: sequencer over one shared multiplier and the divider, holds the
// controller state and the result register; uses pidpi_pkg and pidpi_div
module pidpi_back
   import pidpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_on_target
);

   localparam logic signed [47:0] SUM_MAX = 48'sh7fff_ffff_ffff;
   localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

   seq_state_type state_ff, state_in;
   item_type      cur_ff, cur_in;
   logic          first_ff, first_in, arrived_ff, arrived_in;
   logic signed [31:0] last_ff, last_in, prior_ff, prior_in;
   logic signed [47:0] sum_ff, sum_in;
   logic signed [42:0] p_ff, p_in, d_ff, d_in, i_ff, i_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [58:0] prod_ff;
   logic signed [24:0] mul_a;
   logic signed [33:0] mul_b;
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] drive_ff, drive_in;
   logic               on_ff, on_in;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic signed [42:0] prod_q;
   logic signed [48:0] sum_wide, sum49;
   logic [48:0]        mag_sum;
   logic signed [32:0] e33;
   logic [32:0]        mag_e;
   logic signed [43:0] p44, d44;
   logic [43:0]        mag_p, mag_d;
   logic signed [63:0] tot;
   logic signed [44:0] y, lim;
   logic               s_pos, s_neg, e_pos, e_neg, pos;

   pidpi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_empty     = !out_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_on_target = on_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      arrived_in   = arrived_ff;
      last_in      = last_ff;
      prior_in     = prior_ff;
      sum_in       = sum_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      drive_in     = drive_ff;
      on_in        = on_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      q_pop        = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_req.start    = 1'b0;
      div_req.dividend = {cfg.integral_limit, 16'd0};
      div_req.divisor  = cfg.gain_i;

      pos      = (cur_ff.cmd == CMD_POS);
      prod_q   = $signed(prod_ff[58:16]);
      e33      = 33'(cur_ff.err);
      mag_e    = e33[32] ? 33'(-e33) : 33'(e33);
      sum_wide = 49'(sum_ff) + 49'(cur_ff.err);
      sum49    = 49'(sum_ff);
      mag_sum  = sum49[48] ? 49'(-sum49) : 49'(sum49);
      p44      = 44'(p_ff);
      mag_p    = p44[43] ? 44'(-p44) : 44'(p44);
      d44      = 44'(d_ff);
      mag_d    = d44[43] ? 44'(-d44) : 44'(d44);
      s_pos    = !sum_ff[47] && (sum_ff != '0);
      s_neg    = sum_ff[47];
      e_pos    = !cur_ff.err[31] && (cur_ff.err != '0);
      e_neg    = cur_ff.err[31];
      tot      = acc_ff + (64'(prod_ff) <<< 24);
      y        = 45'(p_ff) + 45'(i_ff) + 45'(d_ff);
      lim      = 45'(cfg.output_limit);

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               priority case (q_item.cmd)
                  CMD_RESTART: begin
                     first_in   = 1'b1;
                     arrived_in = 1'b0;
                  end
                  CMD_POS: begin
                     if (first_ff) begin
                        first_in = 1'b0;
                        last_in  = q_item.err;
                        sum_in   = '0;
                     end
                     state_in = ST_P;
                  end
                  default: state_in = ST_P;
               endcase
            end
         end
         ST_P: begin
            mul_a = $signed({1'b0, cfg.gain_p});
            mul_b = pos ? 34'(cur_ff.err) : 34'(cur_ff.err) - 34'(last_ff);
            state_in = ST_D;
         end
         ST_D: begin
            p_in  = prod_q;
            mul_a = $signed({1'b0, cfg.gain_d});
            mul_b = pos ? 34'(cur_ff.err) - 34'(last_ff)
                        : 34'(cur_ff.err) - (34'(last_ff) <<< 1) + 34'(prior_ff);
            state_in = pos ? ST_SUM : ST_INC_I;
         end
         ST_SUM: begin
            d_in    = prod_q;
            last_in = cur_ff.err;
            if (mag_p >= 44'(cfg.integral_range)) begin
               sum_in = '0;
            end else if (sum_wide[48] != sum_wide[47]) begin
               sum_in = sum_wide[48] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_in = sum_wide[47:0];
            end
            if (cfg.gain_i != '0) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_DIV: begin
            // clamp the sum so that its integral term stays within limit
            if (div_rsp.done) begin
               if (mag_sum > {2'b00, div_rsp.quotient}) begin
                  sum_in = sum_ff[47] ? -48'(div_rsp.quotient) : 48'(div_rsp.quotient);
               end
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if ((s_pos != e_pos) || (s_neg != e_neg) ||
                (mag_e <= 33'(cfg.error_tolerance))) begin
               sum_in = '0;
            end
            arrived_in = (mag_e <= 33'(cfg.error_tolerance)) &&
                         (mag_d <= 44'(cfg.rate_tolerance));
            state_in = ST_ILO;
         end
         ST_ILO: begin
            mul_a    = $signed({1'b0, cfg.gain_i});
            mul_b    = $signed({10'd0, sum_ff[23:0]});
            state_in = ST_IHI;
         end
         ST_IHI: begin
            acc_in   = 64'(prod_ff);
            mul_a    = $signed({1'b0, cfg.gain_i});
            mul_b    = 34'($signed(sum_ff[47:24]));
            state_in = ST_IACC;
         end
         ST_IACC: begin
            i_in     = $signed(tot[58:16]);
            state_in = ST_Y;
         end
         ST_INC_I: begin
            d_in     = prod_q;
            mul_a    = $signed({1'b0, cfg.gain_i});
            mul_b    = 34'(cur_ff.err);
            prior_in = last_ff;
            last_in  = cur_ff.err;
            state_in = ST_INC_Y;
         end
         ST_INC_Y: begin
            i_in     = prod_q;
            state_in = ST_Y;
         end
         ST_Y: begin
            if (!out_valid_ff) begin
               priority if (y > lim) begin
                  drive_in = lim[31:0];
               end else if (y < -lim) begin
                  drive_in = 32'(-lim);
               end else begin
                  drive_in = y[31:0];
               end
               on_in        = arrived_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         arrived_ff   <= 1'b0;
         last_ff      <= '0;
         prior_ff     <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         arrived_ff   <= arrived_in;
         last_ff      <= last_in;
         prior_ff     <= prior_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      p_ff     <= p_in;
      d_ff     <= d_in;
      i_ff     <= i_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
      on_ff    <= on_in;
   end

endmodule

[src/pid_position_incremental_unit.sv]
// pid controller, positional and incremental update, q16.16 fixed point
// positional words wait on the integral bound divider unless the integral gain is zero
// throughput: one word at a time in the back end; the front queue holds two more
// restart leaves the queue without entering the sequence, unused commands are dropped at the input; no result
// reset (synchronous, active high) loads register defaults and clears the state
// depends on pidpi_pkg, pidpi_front, pidpi_back
module pid_position_incremental_unit
   import pidpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input word
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_setpoint,
   input  logic signed [31:0] req_measured,
   // result word
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_on_target,
   // register writes
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;

   // register file; the user must write it only while the unit is idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= '0;
         cfg_ff.gain_i          <= '0;
         cfg_ff.gain_d          <= '0;
         cfg_ff.output_limit    <= '0;
         cfg_ff.integral_range  <= 31'd3276800;  // 50.0
         cfg_ff.integral_limit  <= 31'd1310720;  // 20.0
         cfg_ff.error_tolerance <= '0;
         cfg_ff.rate_tolerance  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_P:    cfg_ff.gain_p          <= csr_wdata[23:0];
            REG_GAIN_I:    cfg_ff.gain_i          <= csr_wdata[23:0];
            REG_GAIN_D:    cfg_ff.gain_d          <= csr_wdata[23:0];
            REG_OUT_LIM:   cfg_ff.output_limit    <= csr_wdata;
            REG_INT_RANGE: cfg_ff.integral_range  <= csr_wdata;
            REG_INT_LIM:   cfg_ff.integral_limit  <= csr_wdata;
            REG_ERR_TOL:   cfg_ff.error_tolerance <= csr_wdata;
            REG_RATE_TOL:  cfg_ff.rate_tolerance  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: error and classification, short queue
   pidpi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .cmd      (req_cmd),
      .setpoint (req_setpoint),
      .measured (req_measured),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   // back: sequencer, shared multiplier, divider, result register
   pidpi_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_drive     (rsp_drive),
      .rsp_on_target (rsp_on_target)
   );

endmodule
